/* hdl/fskd_pkg.sv */
// ----------------------------------------------------------------------------
// fskd_pkg
// Shared types, constants and the sine table generator for the two-tone
// FSK bit demodulator.
// ----------------------------------------------------------------------------
package fskd_pkg;

    // Default build parameters
    localparam int PHASE_BITS_DEF      = 16;
    localparam int SINE_TABLE_BITS_DEF = 10;

    // Field and datapath widths
    localparam int SAMPLE_W   = 16;
    localparam int TRIG_W     = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MULT_A_W   = 33;   // filter difference, widest operand
    localparam int MULT_B_W   = 18;   // alpha zero-extended, squared Q16 value
    localparam int PROD_W     = MULT_A_W + MULT_B_W;
    localparam int LP_W       = 32;   // Q30 filter state
    localparam int SQ_IN_W    = 18;   // filter state floored to Q16
    localparam int SCORE_W    = 48;
    localparam int TIMER_W    = 17;
    localparam int OUT_DATA_W = 8;

    // Register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_STEP  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACE_STEP = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_LEN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MARK_ONE   = 3'd4;

    // Register reset values
    localparam logic [15:0] MARK_STEP_RST  = 16'd7100;
    localparam logic [15:0] SPACE_STEP_RST = 16'd11469;
    localparam logic [15:0] ALPHA_RST      = 16'd39644;
    localparam logic [15:0] SYMBOL_LEN_RST = 16'd2560;
    localparam logic        MARK_ONE_RST   = 1'b1;

    // One sample in Q8.8
    localparam logic [15:0] ONE_SAMPLE_Q8 = 16'd256;

    // Quarter-wave polynomial coefficients, Q15
    localparam longint POLY_A = 51472;
    localparam longint POLY_B = 21024;
    localparam longint POLY_C = 2320;

    typedef struct packed {
        logic [15:0] mark_step;
        logic [15:0] space_step;
        logic [15:0] alpha;
        logic [15:0] symbol_len;
        logic        mark_one;
    } t_cfg;

    // Sine table entry k of a 2^table_bits table over one turn, signed Q15
    function automatic logic signed [TRIG_W-1:0] sine_entry(input int k, input int table_bits);
        int     qb;
        int     quad;
        int     r;
        longint z;
        longint z2;
        longint t;
        qb   = table_bits - 2;
        quad = (k >> qb) & 3;
        r    = k & ((1 << qb) - 1);
        z    = longint'(r) << (15 - qb);
        if ((quad & 1) != 0) begin
            z = 32768 - z;
        end
        z2 = (z * z) >>> 15;
        t  = (POLY_C * z2) >>> 15;
        t  = POLY_B - t;
        t  = (t * z2) >>> 15;
        t  = POLY_A - t;
        t  = (t * z) >>> 15;
        if (t > 32767) begin
            t = 32767;
        end
        if ((quad & 2) != 0) begin
            t = -t;
        end
        return TRIG_W'(t);
    endfunction

endpackage

/* hdl/fskd_sine_rom.sv */
// ----------------------------------------------------------------------------
// fskd_sine_rom
// Full-turn sine table with a registered read port.
// ----------------------------------------------------------------------------
module fskd_sine_rom
    import fskd_pkg::*;
#(
    parameter int TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic [TABLE_BITS-1:0]    i_addr,
    output logic signed [TRIG_W-1:0] o_data
);

    localparam int ROM_SIZE = 1 << TABLE_BITS;

    logic signed [TRIG_W-1:0] w_rom [ROM_SIZE];
    logic signed [TRIG_W-1:0] r_data;

    // Table contents fixed at elaboration
    for (genvar g = 0; g < ROM_SIZE; g++) begin : g_rom
        assign w_rom[g] = sine_entry(g, TABLE_BITS);
    end

    // Registered read
    always_ff @(posedge i_clk) begin
        r_data <= w_rom[i_addr];
    end

    assign o_data = r_data;

endmodule

/* hdl/fskd_mult.sv */
// ----------------------------------------------------------------------------
// fskd_mult
// Shared signed multiplier with a registered product and load enable.
// ----------------------------------------------------------------------------
module fskd_mult
    import fskd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic signed [MULT_A_W-1:0] i_a,
    input  logic signed [MULT_B_W-1:0] i_b,
    output logic signed [PROD_W-1:0]   o_prod
);

    logic signed [PROD_W-1:0] r_prod;

    // Product held until the next operation is issued
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

/* hdl/fskd_cfg.sv */
// ----------------------------------------------------------------------------
// fskd_cfg
// Configuration registers; flags a datapath clear on any retuning write.
// ----------------------------------------------------------------------------
module fskd_cfg
    import fskd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output t_cfg                  o_cfg,
    output logic                  o_clear
);

    t_cfg r_cfg;
    t_cfg n_cfg;
    logic w_wr;

    assign o_cfg_ready = 1'b1;
    assign w_wr        = i_cfg_valid;

    // Register decode
    always_comb begin
        n_cfg   = r_cfg;
        o_clear = 1'b0;
        if (w_wr) begin
            unique case (i_cfg_index)
                CFG_MARK_STEP: begin
                    n_cfg.mark_step = i_cfg_data;
                    o_clear         = 1'b1;
                end
                CFG_SPACE_STEP: begin
                    n_cfg.space_step = i_cfg_data;
                    o_clear          = 1'b1;
                end
                CFG_ALPHA: begin
                    n_cfg.alpha = i_cfg_data;
                    o_clear     = 1'b1;
                end
                CFG_SYMBOL_LEN: begin
                    n_cfg.symbol_len = i_cfg_data;
                    o_clear          = 1'b1;
                end
                CFG_MARK_ONE: begin
                    n_cfg.mark_one = i_cfg_data[0];
                end
                default: begin
                    n_cfg = r_cfg;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mark_step  <= MARK_STEP_RST;
            r_cfg.space_step <= SPACE_STEP_RST;
            r_cfg.alpha      <= ALPHA_RST;
            r_cfg.symbol_len <= SYMBOL_LEN_RST;
            r_cfg.mark_one   <= MARK_ONE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/two_tone_fsk_bit_demodulator.sv */
// ----------------------------------------------------------------------------
// two_tone_fsk_bit_demodulator
// Noncoherent two-tone FSK bit demodulator built around one shared multiplier.
//
// Usage:
//   Slave stream takes one Q15 audio sample in tdata with the squelch flag in
//   tuser. A sample with the squelch closed is taken in one transfer and
//   dropped. An open sample runs through a sequencer: one sine table read,
//   then for each of the four filter lanes a mix product, a filter product
//   and an energy square on the shared multiplier, then a closing step that
//   advances the oscillators and the symbol timer. Ready is high only when
//   the sequencer is idle, so an open sample is finished before the next one
//   is taken; a decided bit is registered on the master stream by the closing
//   step. Up to one bit per sample, none at most sample times.
//   The result sits in an output register, so the next sample is taken while
//   a bit waits; if the receiver still holds the previous bit when a sample
//   reaches the closing step, that step waits until the bit is taken.
//   Configuration writes are taken every cycle; writing a tone step, alpha or
//   symbol length clears oscillators, filters, timer and score. Reset loads
//   the default tuning and clears all state, with no clearing pass.
// ----------------------------------------------------------------------------
module two_tone_fsk_bit_demodulator
    import fskd_pkg::*;
#(
    parameter int PHASE_BITS      = PHASE_BITS_DEF,
    parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [SAMPLE_W-1:0]   i_s_tdata,    // [15:0] audio_sample
    input  logic                  i_s_tuser,    // [0] squelch_open
    // Output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [OUT_DATA_W-1:0] o_m_tdata,    // [0] bit_value, [7:1] zero
    // Configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int          TB      = SINE_TABLE_BITS;
    localparam int          QUARTER = 1 << (TB - 2);
    localparam logic [1:0]  LAST_LANE = 2'd3;

    // Sequencer states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_READ  = 2'd1;
    localparam logic [1:0] ST_LANE  = 2'd2;
    localparam logic [1:0] ST_FINAL = 2'd3;

    // Steps within one filter lane
    localparam logic [2:0] PH_MIX    = 3'd0;
    localparam logic [2:0] PH_DIFF   = 3'd1;
    localparam logic [2:0] PH_ALPHA  = 3'd2;
    localparam logic [2:0] PH_UPDATE = 3'd3;
    localparam logic [2:0] PH_SQUARE = 3'd4;

    t_cfg w_cfg;
    logic w_clear;

    logic [1:0] r_state;
    logic [2:0] r_ph;
    logic [1:0] r_lane;

    logic signed [SAMPLE_W-1:0] r_x;
    logic [PHASE_BITS-1:0]      r_mark_phase;
    logic [PHASE_BITS-1:0]      r_space_phase;
    logic signed [LP_W-1:0]     r_lp [4];
    logic signed [LP_W-1:0]     r_mix;
    logic signed [MULT_A_W-1:0] r_diff;
    logic signed [SCORE_W-1:0]  r_score;
    logic [TIMER_W-1:0]         r_timer;
    logic                       r_m_tvalid;
    logic                       r_bit;

    logic [PHASE_BITS-1:0]      w_mark_inc;
    logic [PHASE_BITS-1:0]      w_space_inc;
    logic [TB-1:0]              w_mark_idx;
    logic [TB-1:0]              w_space_idx;
    logic [1:0]                 w_addr_lane;
    logic [TB-1:0]              w_rom_addr;
    logic signed [TRIG_W-1:0]   w_trig;
    logic signed [MULT_B_W-1:0] w_trig_ext;

    logic                       w_mult_en;
    logic signed [MULT_A_W-1:0] w_mult_a;
    logic signed [MULT_B_W-1:0] w_mult_b;
    logic signed [PROD_W-1:0]   w_prod;

    logic signed [LP_W-1:0]     w_lp_cur;
    logic signed [SQ_IN_W-1:0]  w_lp_q16;
    logic signed [PROD_W-1:0]   w_acc;
    logic signed [SCORE_W-1:0]  w_sq;
    logic signed [SCORE_W-1:0]  w_score_final;
    logic [15:0]                w_len;
    logic [TIMER_W-1:0]         w_timer_inc;
    logic                       w_decide;
    logic                       w_s_xfer;
    logic                       w_final_go;

    // ------------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------------
    fskd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg),
        .o_clear     (w_clear)
    );

    // ------------------------------------------------------------------------
    // Phase step scaling and table index from the phase accumulators
    // ------------------------------------------------------------------------
    if (PHASE_BITS > 16) begin : g_step_up
        assign w_mark_inc  = {w_cfg.mark_step, {(PHASE_BITS-16){1'b0}}};
        assign w_space_inc = {w_cfg.space_step, {(PHASE_BITS-16){1'b0}}};
    end else if (PHASE_BITS == 16) begin : g_step_eq
        assign w_mark_inc  = w_cfg.mark_step;
        assign w_space_inc = w_cfg.space_step;
    end else begin : g_step_dn
        assign w_mark_inc  = w_cfg.mark_step[15 -: PHASE_BITS];
        assign w_space_inc = w_cfg.space_step[15 -: PHASE_BITS];
    end

    if (PHASE_BITS > TB) begin : g_idx_top
        assign w_mark_idx  = r_mark_phase[PHASE_BITS-1 -: TB];
        assign w_space_idx = r_space_phase[PHASE_BITS-1 -: TB];
    end else if (PHASE_BITS == TB) begin : g_idx_eq
        assign w_mark_idx  = r_mark_phase;
        assign w_space_idx = r_space_phase;
    end else begin : g_idx_pad
        assign w_mark_idx  = {r_mark_phase, {(TB-PHASE_BITS){1'b0}}};
        assign w_space_idx = {r_space_phase, {(TB-PHASE_BITS){1'b0}}};
    end

    // Lane order: mark cos, mark sin, space cos, space sin
    assign w_addr_lane = (r_state == ST_READ) ? 2'd0 : r_lane + 2'd1;

    always_comb begin
        unique case (w_addr_lane)
            2'd0:    w_rom_addr = w_mark_idx + TB'(QUARTER);
            2'd1:    w_rom_addr = w_mark_idx;
            2'd2:    w_rom_addr = w_space_idx + TB'(QUARTER);
            default: w_rom_addr = w_space_idx;
        endcase
    end

    fskd_sine_rom #(
        .TABLE_BITS (TB)
    ) u_rom (
        .i_clk  (i_clk),
        .i_addr (w_rom_addr),
        .o_data (w_trig)
    );

    // ------------------------------------------------------------------------
    // Shared multiplier operand select
    // ------------------------------------------------------------------------
    assign w_trig_ext = MULT_B_W'(w_trig);
    assign w_lp_cur   = r_lp[r_lane];
    assign w_lp_q16   = w_lp_cur[LP_W-1 -: SQ_IN_W];

    always_comb begin
        w_mult_en = 1'b0;
        w_mult_a  = '0;
        w_mult_b  = '0;
        if (r_state == ST_LANE) begin
            unique case (r_ph)
                PH_MIX: begin
                    // Quadrature lanes take minus sine
                    w_mult_en = 1'b1;
                    w_mult_a  = MULT_A_W'(r_x);
                    w_mult_b  = r_lane[0] ? -w_trig_ext : w_trig_ext;
                end
                PH_ALPHA: begin
                    w_mult_en = 1'b1;
                    w_mult_a  = r_diff;
                    w_mult_b  = MULT_B_W'($signed({1'b0, w_cfg.alpha}));
                end
                PH_SQUARE: begin
                    w_mult_en = 1'b1;
                    w_mult_a  = MULT_A_W'(w_lp_q16);
                    w_mult_b  = MULT_B_W'(w_lp_q16);
                end
                default: begin
                    w_mult_en = 1'b0;
                end
            endcase
        end
    end

    fskd_mult u_mult (
        .i_clk  (i_clk),
        .i_en   (w_mult_en),
        .i_a    (w_mult_a),
        .i_b    (w_mult_b),
        .o_prod (w_prod)
    );

    // ------------------------------------------------------------------------
    // Filter update, energy and symbol timing
    // ------------------------------------------------------------------------
    // mix*65536 + alpha*(v - mix), rounded then floored by 16
    assign w_acc = $signed({{3{r_mix[LP_W-1]}}, r_mix, 16'b0}) + w_prod + PROD_W'(32768);
    assign w_sq  = w_prod[SCORE_W-1:0];

    assign w_score_final = r_score - w_sq;
    assign w_len         = (w_cfg.symbol_len < ONE_SAMPLE_Q8) ? ONE_SAMPLE_Q8
                                                              : w_cfg.symbol_len;
    assign w_timer_inc   = r_timer + TIMER_W'(ONE_SAMPLE_Q8);
    assign w_decide      = (w_timer_inc >= TIMER_W'(w_len));

    assign w_s_xfer   = i_s_tvalid && o_s_tready;
    assign w_final_go = (r_state == ST_FINAL) && (!r_m_tvalid || i_m_tready);

    // ------------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_ph    <= PH_MIX;
            r_lane  <= 2'd0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_s_xfer && i_s_tuser) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    r_state <= ST_LANE;
                    r_ph    <= PH_MIX;
                    r_lane  <= 2'd0;
                end
                ST_LANE: begin
                    unique case (r_ph)
                        PH_MIX:    r_ph <= PH_DIFF;
                        PH_DIFF:   r_ph <= PH_ALPHA;
                        PH_ALPHA:  r_ph <= PH_UPDATE;
                        PH_UPDATE: r_ph <= PH_SQUARE;
                        default: begin
                            r_ph <= PH_MIX;
                            if (r_lane == LAST_LANE) begin
                                r_state <= ST_FINAL;
                            end else begin
                                r_lane <= r_lane + 2'd1;
                            end
                        end
                    endcase
                end
                default: begin
                    if (w_final_go) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
        end
    end

    // Sample register
    always_ff @(posedge i_clk) begin
        if (w_s_xfer) begin
            r_x <= $signed(i_s_tdata);
        end
    end

    // Mix and difference registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_LANE && r_ph == PH_DIFF) begin
            r_mix  <= w_prod[LP_W-1:0];
            r_diff <= MULT_A_W'(w_lp_cur) - MULT_A_W'($signed(w_prod[LP_W-1:0]));
        end
    end

    // Datapath state: filters, oscillators, score and timer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_clear) begin
            r_mark_phase  <= '0;
            r_space_phase <= '0;
            r_lp[0]       <= '0;
            r_lp[1]       <= '0;
            r_lp[2]       <= '0;
            r_lp[3]       <= '0;
            r_score       <= '0;
            r_timer       <= '0;
        end else begin
            if (r_state == ST_LANE && r_ph == PH_UPDATE) begin
                r_lp[r_lane] <= w_acc[LP_W+15:16];
            end
            // Square of the previous lane: mark lanes add, space lanes subtract
            if (r_state == ST_LANE && r_ph == PH_MIX && r_lane != 2'd0) begin
                if (r_lane == LAST_LANE) begin
                    r_score <= r_score - w_sq;
                end else begin
                    r_score <= r_score + w_sq;
                end
            end
            if (w_final_go) begin
                r_mark_phase  <= r_mark_phase + w_mark_inc;
                r_space_phase <= r_space_phase + w_space_inc;
                if (w_decide) begin
                    r_timer <= w_timer_inc - TIMER_W'(w_len);
                    r_score <= '0;
                end else begin
                    r_timer <= w_timer_inc;
                    r_score <= w_score_final;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else begin
            priority if (w_final_go && w_decide) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_final_go && w_decide) begin
            r_bit <= ((w_score_final >= 0) == w_cfg.mark_one);
        end
    end

    assign o_s_tready = (r_state == ST_IDLE);
    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = {{(OUT_DATA_W-1){1'b0}}, r_bit};

endmodule

/* tb/fskd_bit_scoreboard_pkg.sv */
// ----------------------------------------------------------------------------
// fskd_bit_scoreboard_pkg
// Bit predictor and in-order checker for the two-tone FSK bit demodulator.
// Every accepted sample with the squelch open runs through a fixed-point copy
// of the mixer, filter, energy and symbol timer datapath. Each decided bit is
// queued and compared with the next bit that the block delivers.
// ----------------------------------------------------------------------------
package fskd_bit_scoreboard_pkg;
    import fskd_pkg::*;

    localparam int TABLE_SIZE  = 1 << SINE_TABLE_BITS_DEF;
    localparam int QUARTER     = TABLE_SIZE / 4;
    localparam int INDEX_SHIFT = PHASE_BITS_DEF - SINE_TABLE_BITS_DEF;

    class fsk_bit_scoreboard;
        int          sine_q15 [TABLE_SIZE];
        // tuning registers
        int          mark_step;
        int          space_step;
        int          alpha;
        int          symbol_len;
        bit          mark_one;
        // datapath state
        logic [15:0] mark_phase;
        logic [15:0] space_phase;
        int          lane [4];      // mark I, mark Q, space I, space Q (Q30)
        int          timer_q8;
        longint      score;
        // bits decided but not yet delivered
        bit          expected_bits [$];
        int          errors;

        function new();
            build_sine();
            mark_step  = MARK_STEP_RST;
            space_step = SPACE_STEP_RST;
            alpha      = ALPHA_RST;
            symbol_len = SYMBOL_LEN_RST;
            mark_one   = MARK_ONE_RST;
            errors     = 0;
            clear_datapath();
        endfunction

        // Quarter-wave polynomial folded out to a full turn
        function void build_sine();
            int     k;
            int     quad;
            longint z;
            longint z2;
            longint t;
            for (k = 0; k < TABLE_SIZE; k++) begin
                quad = (k / QUARTER) % 4;
                z    = longint'(k % QUARTER) * (32768 / QUARTER);
                if (quad % 2 == 1) begin
                    z = 32768 - z;
                end
                z2 = (z * z) >>> 15;
                t  = POLY_B - ((POLY_C * z2) >>> 15);
                t  = POLY_A - ((t * z2) >>> 15);
                t  = (t * z) >>> 15;
                if (t > 32767) begin
                    t = 32767;
                end
                sine_q15[k] = (quad >= 2) ? -int'(t) : int'(t);
            end
        endfunction

        function void clear_datapath();
            mark_phase  = '0;
            space_phase = '0;
            lane        = '{0, 0, 0, 0};
            timer_q8    = 0;
            score       = 0;
        endfunction

        // One-pole low-pass, rounded then floored back to Q30
        function int lowpass(int v, longint mix);
            longint acc;
            acc = longint'(alpha) * v + longint'(65536 - alpha) * mix;
            return int'((acc + 32768) >>> 16);
        endfunction

        // I/Q energy in Q32 after flooring each lane to Q16
        function longint tone_energy(int i, int q);
            longint a;
            longint b;
            a = i >>> 14;
            b = q >>> 14;
            return a * a + b * b;
        endfunction

        // Register write as seen by the block; tuning writes restart the datapath
        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_MARK_STEP: begin
                    mark_step = data;
                    clear_datapath();
                end
                CFG_SPACE_STEP: begin
                    space_step = data;
                    clear_datapath();
                end
                CFG_ALPHA: begin
                    alpha = data;
                    clear_datapath();
                end
                CFG_SYMBOL_LEN: begin
                    symbol_len = data;
                    clear_datapath();
                end
                CFG_MARK_ONE: begin
                    mark_one = data[0];
                end
                default: begin
                end
            endcase
        endfunction

        // Accepted sample: advance the datapath and queue a bit at symbol end
        function void take_sample(logic [SAMPLE_W-1:0] raw, logic open);
            longint x;
            int     mi;
            int     si;
            int     len;
            if (!open) begin
                return;
            end
            x  = longint'($signed(raw));
            mi = mark_phase >> INDEX_SHIFT;
            si = space_phase >> INDEX_SHIFT;
            lane[0] = lowpass(lane[0], x * sine_q15[(mi + QUARTER) % TABLE_SIZE]);
            lane[1] = lowpass(lane[1], -x * sine_q15[mi]);
            lane[2] = lowpass(lane[2], x * sine_q15[(si + QUARTER) % TABLE_SIZE]);
            lane[3] = lowpass(lane[3], -x * sine_q15[si]);
            mark_phase  = mark_phase + 16'(mark_step);
            space_phase = space_phase + 16'(space_step);
            score = score + tone_energy(lane[0], lane[1]) - tone_energy(lane[2], lane[3]);
            timer_q8 = timer_q8 + 256;
            // anything shorter than one sample counts as one sample
            len = (symbol_len < 256) ? 256 : symbol_len;
            if (timer_q8 >= len) begin
                timer_q8 = timer_q8 - len;
                expected_bits.push_back((score >= 0) == mark_one);
                score = 0;
            end
        endfunction

        // Delivered bit against the oldest decided bit
        function void check_bit(logic [OUT_DATA_W-1:0] tdata);
            bit want;
            if (expected_bits.size() == 0) begin
                $error("bit_value: expected none, actual %0d", tdata[0]);
                errors++;
                return;
            end
            want = expected_bits.pop_front();
            if (tdata[0] !== want) begin
                $error("bit_value: expected %0d, actual %0d", want, tdata[0]);
                errors++;
            end
            if (tdata[OUT_DATA_W-1:1] !== '0) begin
                $error("tdata padding: expected 0, actual %0h", tdata[OUT_DATA_W-1:1]);
                errors++;
            end
        endfunction

        function int pending();
            return expected_bits.size();
        endfunction
    endclass

endpackage

/* tb/tb_two_tone_fsk_bit_demodulator.sv */
// ----------------------------------------------------------------------------
// tb_two_tone_fsk_bit_demodulator
// Self-checking bench for the two-tone FSK bit demodulator. A short directed
// run at reset tuning is followed by phases at extreme and random tunings,
// fed mostly with synthesised mark/space tone bursts plus raw noise, with
// random squelch, random gaps on both streams, a long receiver hold-off and
// register writes between phases once the block has gone quiet.
// ----------------------------------------------------------------------------
module tb_two_tone_fsk_bit_demodulator;
    timeunit 1ns;
    timeprecision 1ps;

    import fskd_pkg::*;
    import fskd_bit_scoreboard_pkg::*;

    localparam int SETTLE_CYCLES  = 40;    // beyond one sample sequence
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [SAMPLE_W-1:0]   i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    fsk_bit_scoreboard sb;

    bit          steady  = 1'b0;   // no random gaps on either side
    bit          hold_go = 1'b0;   // request a long receiver hold-off
    int          quiet_cycles = 0;

    // tuning mirror and tone burst generator
    int          cur_mark_step  = MARK_STEP_RST;
    int          cur_space_step = SPACE_STEP_RST;
    int          cur_symbol_len = SYMBOL_LEN_RST;
    logic [15:0] tone_phase = '0;
    bit          tone_space = 1'b0;
    int          tone_left  = 0;
    int          tone_amp   = 0;

    two_tone_fsk_bit_demodulator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Receiver: random back-pressure, or a long hold-off on request
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_go) begin
                hold_go = 1'b0;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                i_m_tready <= steady || ($urandom_range(99) >= 31);
            end
        end
    end

    // Output transfers go to the checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            sb.check_bit(o_m_tdata);
        end
    end

    // Watchdog on cycles with no transfer anywhere
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
            || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_two_tone_fsk_bit_demodulator failed");
            $finish;
        end
    end

    // Offer one sample and wait for its transfer; returns at a falling edge
    task automatic push_sample(input logic [SAMPLE_W-1:0] smp, input logic open);
        while (!steady && $urandom_range(99) < 31) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= smp;
        i_s_tuser  <= open;
        do @(posedge i_clk); while (!o_s_tready);
        sb.take_sample(smp, open);
        @(negedge i_clk);
    endtask

    // One register write; valid is left high for a following write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    // Stop offering, let every bit arrive, then let the sequencer finish
    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic retune(input int mark_step, input int space_step, input int alpha,
                          input int symbol_len, input bit mark_one);
        wait_drained();
        write_reg(CFG_MARK_STEP, 16'(mark_step));
        write_reg(CFG_SPACE_STEP, 16'(space_step));
        write_reg(CFG_ALPHA, 16'(alpha));
        write_reg(CFG_SYMBOL_LEN, 16'(symbol_len));
        write_reg(CFG_MARK_ONE, {15'($urandom), mark_one});
        i_cfg_valid <= 1'b0;
        cur_mark_step  = mark_step;
        cur_space_step = space_step;
        cur_symbol_len = symbol_len;
    endtask

    // Polarity change alone keeps the datapath running; spare indexes do nothing
    task automatic flip_polarity(input bit mark_one);
        int ix;
        wait_drained();
        for (ix = int'(CFG_MARK_ONE) + 1; ix < (1 << CFG_IDX_W); ix++) begin
            write_reg(CFG_IDX_W'(ix), 16'($urandom));
        end
        write_reg(CFG_MARK_ONE, {15'($urandom), mark_one});
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly tone bursts at the current tones and symbol rate, some raw noise
    task automatic next_sample(output logic [SAMPLE_W-1:0] smp, output logic open);
        int v;
        open = ($urandom_range(99) >= 12);
        if ($urandom_range(99) < 80) begin
            if (tone_left <= 0) begin
                tone_space = $urandom_range(1);
                tone_left  = (cur_symbol_len < 512) ? 1 : cur_symbol_len / 256;
                tone_amp   = $urandom_range(32767, 1000);
            end
            if (open) begin
                tone_left--;
            end
            v = (tone_amp * sb.sine_q15[tone_phase >> INDEX_SHIFT]) >>> 15;
            v = v + int'($urandom_range(511)) - 256;
            if (v > 32767) begin
                v = 32767;
            end else if (v < -32768) begin
                v = -32768;
            end
            smp = 16'(v);
            tone_phase = tone_phase + 16'(tone_space ? cur_space_step : cur_mark_step);
        end else begin
            smp = 16'($urandom);
        end
    endtask

    task automatic run_phase(input int n_items, input bit with_pressure);
        int          n;
        logic [15:0] smp;
        logic        open;
        for (n = 0; n < n_items; n++) begin
            if (with_pressure && n == 20) begin
                hold_go = 1'b1;
            end
            // sender pause until the block has delivered everything
            if (with_pressure && n == 90) begin
                i_s_tvalid <= 1'b0;
                do @(negedge i_clk); while (sb.pending() != 0);
            end
            next_sample(smp, open);
            push_sample(smp, open);
        end
    endtask

    initial begin
        int n;
        int p;
        sb = new();
        i_rst_n     = 1'b0;
        i_s_tvalid  = 1'b0;
        i_s_tdata   = '0;
        i_s_tuser   = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        // reset held, then released at a falling edge
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset tuning: sample extremes and alternating bit patterns
        push_sample(16'h7FFF, 1'b1);
        push_sample(16'h8000, 1'b1);
        push_sample(16'h0000, 1'b1);
        push_sample(16'h0001, 1'b1);
        push_sample(16'hFFFF, 1'b1);
        push_sample(16'h5555, 1'b1);
        push_sample(16'hAAAA, 1'b1);
        // squelch closed at the extremes: no effect at all
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7FFF, 1'b0);
        push_sample(16'hFFFF, 1'b0);
        push_sample(16'h0000, 1'b0);
        // full-scale square wave across a couple of symbols
        for (n = 0; n < 13; n++) begin
            push_sample((n % 2 != 0) ? 16'h8000 : 16'h7FFF, 1'b1);
        end

        // extreme tunings, symbol lengths below one sample
        retune(0, 65535, 0, 0, 1'b0);
        run_phase(120, 1'b0);
        retune(65535, 0, 65535, 255, 1'b1);
        run_phase(120, 1'b0);
        retune(MARK_STEP_RST, SPACE_STEP_RST, ALPHA_RST, SYMBOL_LEN_RST, MARK_ONE_RST);
        run_phase(120, 1'b0);
        // polarity flip mid-symbol
        flip_polarity(1'b0);
        run_phase(100, 1'b0);
        // longest symbol
        retune(MARK_STEP_RST, SPACE_STEP_RST, ALPHA_RST, 65535, 1'b1);
        run_phase(60, 1'b0);

        // random tunings; one phase with no gaps, one under back-pressure
        for (p = 0; p < 7; p++) begin
            retune($urandom_range(9000, 4000), $urandom_range(15000, 9000),
                   $urandom_range(65535), $urandom_range(3072, 256), $urandom_range(1));
            steady = (p == 2);
            run_phase(130, p == 4);
        end
        steady = 1'b0;

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("tb_two_tone_fsk_bit_demodulator passed");
        end else begin
            $display("tb_two_tone_fsk_bit_demodulator failed");
        end
        $finish;
    end

endmodule
